[hdl/p1305_pkg.sv]
// Shared types and constants for the Poly1305 MAC core.
// No dependencies; imported by p1305_pad and poly1305_mac_core.
`timescale 1ns / 1ps

package p1305_pkg;

    localparam int LIMB_W   = 26;
    localparam int NLIMB    = 5;
    localparam int CFG_IX_W = 2;

    typedef logic [NLIMB-1:0][LIMB_W-1:0] t_limb5;

    localparam logic [63:0] CLAMP_LO = 64'h0ffffffc0fffffff;
    localparam logic [63:0] CLAMP_HI = 64'h0ffffffc0ffffffc;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_R_LO = 2'd0,
        CFG_R_HI = 2'd1,
        CFG_S_LO = 2'd2,
        CFG_S_HI = 2'd3
    } t_cfg_ix;

endpackage

[hdl/poly1305_mac_core.sv]
// Poly1305 one-time MAC core: key registers, block sequencer, shared limb multiplier.
// Depends on p1305_pkg and p1305_pad.
`timescale 1ns / 1ps

// Usage:
//   Load the 32-byte key through the cfg channel (index 0..3: r low, r high,
//   s low, s high, little-endian 64-bit words) while the core is idle; r is
//   clamped inside. Stream message blocks on the s-side: tdata carries the
//   16 data bytes and the byte count, tlast marks the final block of a
//   message. Each block with a nonzero count runs 25 partial products of a
//   28-bit accumulator limb by a 29-bit r or 5r limb through one multiplier,
//   then a drain state and a carry fold state; input is ready only while
//   idle. A final block then passes through the reduction states and writes
//   the 16-byte tag into the m-side output register; the accumulator is
//   then cleared for the next message. A zero-length final block emits the
//   tag of what was absorbed so far. The output register holds a tag until
//   taken; a further tag waits in the last reduction step while the receiver
//   stalls. Reset clears the key, the accumulator and all handshake state.
module poly1305_mac_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [p1305_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [63:0] block_low, [127:64] block_high, [132:128] block_len, [135:133] zero
    input  logic [135:0]                  i_s_tdata,
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [63:0] tag_low, [127:64] tag_high
    output logic [127:0]                  o_m_tdata
);
    import p1305_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_FOLD,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_FIN4
    } t_state;

    t_state r_state;

    logic [63:0] r_key_r_lo, r_key_r_hi, r_key_s_lo, r_key_s_hi;

    logic [NLIMB-1:0][26:0] r_h;
    logic [NLIMB-1:0][27:0] r_a;
    logic [NLIMB-1:0][25:0] r_rl;
    logic [NLIMB-1:0][28:0] r_r5;
    logic                   r_last;

    logic [2:0]   r_col, r_idx, r_pcol;
    logic         r_pvalid, r_plast;
    logic [56:0]  r_prod;
    logic [60:0]  r_dacc;
    logic [34:0]  r_carry;
    logic [130:0] r_full;
    logic         r_m_tvalid;
    logic [127:0] r_m_tdata;

    logic         s_fire, out_free;
    logic [4:0]   in_len;
    t_limb5       m_limbs;
    logic [129:0] r_clamped;
    logic [2:0]   rsel_ix;
    logic [28:0]  rsel;
    logic [60:0]  n_tot;
    logic [37:0]  n_h0;
    logic [26:0]  n_h1;
    logic [131:0] n_plus5;

    p1305_pad u_pad (
        .i_data  (i_s_tdata[127:0]),
        .i_len   (in_len),
        .o_limbs (m_limbs)
    );

    assign in_len      = i_s_tdata[132:128];
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_tvalid || i_m_tready;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign r_clamped   = {2'b00, r_key_r_hi & CLAMP_HI, r_key_r_lo & CLAMP_LO};

    always_comb begin
        rsel_ix = (r_col >= r_idx) ? (r_col - r_idx) : (r_col + 3'd5 - r_idx);
        rsel    = (r_idx <= r_col) ? 29'(r_rl[rsel_ix]) : r_r5[rsel_ix];
        n_tot   = r_dacc + 61'(r_prod) + 61'(r_carry);
        n_h0    = 38'({r_carry, 2'b00}) + 38'(r_carry) + 38'(r_h[0]);
        n_h1    = 27'(r_h[1][25:0]) + 27'(n_h0[37:26]);
        n_plus5 = 132'(r_full) + 132'd5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_key_r_lo <= '0;
            r_key_r_hi <= '0;
            r_key_s_lo <= '0;
            r_key_s_hi <= '0;
            r_h        <= '0;
            r_col      <= '0;
            r_idx      <= '0;
            r_pvalid   <= 1'b0;
            r_plast    <= 1'b0;
            r_dacc     <= '0;
            r_carry    <= '0;
            r_m_tvalid <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_ix'(i_cfg_index))
                    CFG_R_LO: r_key_r_lo <= i_cfg_data;
                    CFG_R_HI: r_key_r_hi <= i_cfg_data;
                    CFG_S_LO: r_key_s_lo <= i_cfg_data;
                    CFG_S_HI: r_key_s_hi <= i_cfg_data;
                    default:  r_key_r_lo <= r_key_r_lo;
                endcase
            end

            if (r_m_tvalid && i_m_tready && r_state != ST_FIN4) begin
                r_m_tvalid <= 1'b0;
            end

            // product pipeline: one column finishes on its fifth product
            r_pvalid <= (r_state == ST_MUL);
            r_plast  <= (r_idx == 3'd4);
            r_pcol   <= r_col;
            r_prod   <= 57'(r_a[r_idx]) * 57'(rsel);
            if (r_pvalid) begin
                if (r_plast) begin
                    r_h[r_pcol] <= 27'(n_tot[25:0]);
                    r_carry     <= n_tot[60:26];
                    r_dacc      <= '0;
                end else begin
                    r_dacc <= r_dacc + 61'(r_prod);
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_fire) begin
                        r_last <= i_s_tlast;
                        for (int k = 0; k < NLIMB; k++) begin
                            r_a[k]  <= 28'(r_h[k]) + 28'(m_limbs[k]);
                            r_rl[k] <= r_clamped[LIMB_W*k +: LIMB_W];
                            r_r5[k] <= 29'({r_clamped[LIMB_W*k +: LIMB_W], 2'b00})
                                       + 29'(r_clamped[LIMB_W*k +: LIMB_W]);
                        end
                        r_col   <= '0;
                        r_idx   <= '0;
                        r_dacc  <= '0;
                        r_carry <= '0;
                        if (in_len != 5'd0) begin
                            r_state <= ST_MUL;
                        end else if (i_s_tlast) begin
                            r_state <= ST_FIN1;
                        end
                    end
                end
                ST_MUL: begin
                    if (r_idx == 3'd4) begin
                        r_idx <= '0;
                        if (r_col == 3'd4) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_col <= r_col + 3'd1;
                        end
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FOLD;
                end
                ST_FOLD: begin
                    r_h[0]  <= 27'(n_h0[25:0]);
                    r_h[1]  <= n_h1;
                    r_state <= r_last ? ST_FIN1 : ST_IDLE;
                end
                ST_FIN1: begin
                    r_full  <= 131'({r_h[4][25:0], r_h[3][25:0], r_h[2][25:0],
                                     r_h[1][25:0], r_h[0][25:0]})
                               + (131'(r_h[1][26]) << 52);
                    r_state <= ST_FIN2;
                end
                ST_FIN2: begin
                    r_full  <= 131'(r_full[129:0]) + (r_full[130] ? 131'd5 : 131'd0);
                    r_state <= ST_FIN3;
                end
                ST_FIN3: begin
                    if (n_plus5[130]) begin
                        r_full <= 131'(n_plus5[127:0]);
                    end
                    r_state <= ST_FIN4;
                end
                ST_FIN4: begin
                    if (out_free) begin
                        r_m_tdata  <= r_full[127:0] + {r_key_s_hi, r_key_s_lo};
                        r_m_tvalid <= 1'b1;
                        r_h        <= '0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_prod_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvalid |-> (r_state == ST_DRAIN || r_state == ST_MUL))
        else $error("product valid outside multiply phase");

    a_nonzero_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_len != 5'd0) |=> (r_state == ST_MUL && r_col == 3'd0 && r_idx == 3'd0))
        else $error("nonzero block did not start multiply");

    a_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_col < 3'd5 && r_idx < 3'd5))
        else $error("column or index counter out of range");

    a_clear_after_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN4 && out_free) |=> (r_h == '0 && r_m_tvalid))
        else $error("accumulator not cleared with tag");

    a_drain_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_pvalid && r_plast && r_pcol == 3'd4))
        else $error("drain without final column");

endmodule

[hdl/p1305_pad.sv]
// Message block padding and split into radix 2^26 limbs.
// Depends on p1305_pkg.
`timescale 1ns / 1ps

module p1305_pad (
    input  logic [127:0]          i_data,
    input  logic [4:0]            i_len,
    output p1305_pkg::t_limb5     o_limbs
);
    import p1305_pkg::*;

    logic [4:0]   len_sat;
    logic [127:0] body;
    logic         top;
    logic [128:0] msg;

    always_comb begin
        len_sat = (i_len > 5'd16) ? 5'd16 : i_len;
        top     = (len_sat == 5'd16);
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < len_sat) begin
                body[8*b +: 8] = i_data[8*b +: 8];
            end else if (5'(b) == len_sat) begin
                body[8*b +: 8] = 8'h01;
            end else begin
                body[8*b +: 8] = 8'h00;
            end
        end
        msg = {top, body};
        for (int k = 0; k < NLIMB - 1; k++) begin
            o_limbs[k] = msg[LIMB_W*k +: LIMB_W];
        end
        o_limbs[NLIMB-1] = 26'(msg[128:104]);
    end

endmodule
